// ===== design/wbwl_pkg.sv =====
// ----------------------------------------------------------------------------
// wbwl_pkg
// Shared widths, constants and controller/datapath interface types for the
// write budget window limiter.
// ----------------------------------------------------------------------------
package wbwl_pkg;

  localparam int HISTORY_DEPTH = 32;
  localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  localparam int TIME_W   = 62;
  localparam int BYTES_W  = 40;
  localparam int BUCKET_W = 48;
  localparam int SUM_W    = 53;
  localparam int TARGET_W = 40;
  localparam int DIFF_W   = TIME_W + 1;
  localparam int LIMIT_W  = TARGET_W + 5;

  localparam logic [DIFF_W-1:0] US_PER_DAY     = DIFF_W'(64'd86400000000);
  localparam logic [DIFF_W-1:0] NEW_BUCKET_GAP = US_PER_DAY;
  localparam logic [DIFF_W-1:0] WIN_MONTH      = DIFF_W'(64'd28 * 64'd86400000000);
  localparam logic [DIFF_W-1:0] WIN_WEEK       = DIFF_W'(64'd7 * 64'd86400000000);
  localparam logic [DIFF_W-1:0] WIN_DAY        = US_PER_DAY;

  localparam logic [BUCKET_W-1:0] BUCKET_MAX = '1;
  localparam logic [SUM_W-1:0]    SUM_MAX    = '1;

  localparam logic [LIMIT_W-1:0] MULT_MONTH = LIMIT_W'(28 * 1);
  localparam logic [LIMIT_W-1:0] MULT_WEEK  = LIMIT_W'(7 * 2);
  localparam logic [LIMIT_W-1:0] MULT_DAY   = LIMIT_W'(1 * 4);

  localparam int  ADDR_W           = 4;
  localparam int  DATA_W           = 64;
  localparam logic REG_DAILY_TARGET = 1'b0;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic rec_we;
    logic cmp_en;
  } wbwl_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             pipe_busy;
  } wbwl_sts_t;

endpackage

// ===== design/wbwl_ctrl.sv =====
// ----------------------------------------------------------------------------
// wbwl_ctrl
// Sequencer: accepts one command word, steps the datapath through a bucket
// update or a ring walk, and strobes the query result.
// ----------------------------------------------------------------------------
module wbwl_ctrl
  import wbwl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_func,
  output logic      busy,
  output logic      out_valid,
  output wbwl_cmd_t cmd,
  input  wbwl_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REC_RD,
    S_REC_WAIT,
    S_REC_WR,
    S_QRY_WALK,
    S_QRY_DRAIN,
    S_QRY_CMP,
    S_QRY_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          left_nxt = sts.count;
          state_nxt = (in_func == FUNC_QUERY) ? S_QRY_WALK : S_REC_RD;
        end
      end
      S_REC_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_REC_WAIT;
      end
      S_REC_WAIT: state_nxt = S_REC_WR;
      S_REC_WR: begin
        cmd.rec_we = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_QRY_WALK: begin
        cmd.rd_en = 1'b1;
        left_nxt  = left_r - CNT_W'(1);
        if (left_r <= CNT_W'(1)) state_nxt = S_QRY_DRAIN;
      end
      S_QRY_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_QRY_CMP;
      end
      S_QRY_CMP: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = S_QRY_OUT;
      end
      S_QRY_OUT: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_QRY_OUT);

endmodule

// ===== design/wbwl_dpath.sv =====
// ----------------------------------------------------------------------------
// wbwl_dpath
// Bucket ring memory, ring pointers, age pipeline, saturating window
// accumulators and limit compare.
// ----------------------------------------------------------------------------
module wbwl_dpath
  import wbwl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  wbwl_cmd_t           cmd,
  output wbwl_sts_t           sts,
  input  logic [TIME_W-1:0]   in_time_us,
  input  logic [BYTES_W-1:0]  in_write_bytes,
  input  logic [TARGET_W-1:0] daily_target,
  output logic                out_allowed,
  output logic [SUM_W-1:0]    out_sum_month,
  output logic [SUM_W-1:0]    out_sum_week,
  output logic [SUM_W-1:0]    out_sum_day
);

  logic [TIME_W-1:0]   mem_start [HISTORY_DEPTH];
  logic [BUCKET_W-1:0] mem_bytes [HISTORY_DEPTH];

  logic [SLOT_W-1:0]   newest_r;
  logic [CNT_W-1:0]    count_r;
  logic                v0_r;
  logic [SLOT_W-1:0]   rd_addr_r;
  logic [TIME_W-1:0]   time_r;
  logic [BYTES_W-1:0]  bytes_r;

  logic                v1_r, v2_r, v3_r;
  logic                zero1_r;
  logic [TIME_W-1:0]   start1_r, start2_r;
  logic [BUCKET_W-1:0] bytes1_r, bytes2_r, bytes3_r;
  logic [DIFF_W-1:0]   diff2_r;
  logic                in_month_r, in_week_r, in_day_r;

  logic [SUM_W-1:0]    s_month_r, s_week_r, s_day_r;
  logic [LIMIT_W-1:0]  lim_month_r, lim_week_r, lim_day_r;
  logic                allowed_r;

  logic [TIME_W-1:0]   start1_m;
  logic [BUCKET_W-1:0] bytes1_m;
  logic [SLOT_W-1:0]   next_slot, prev_slot, wr_addr;
  logic                gap;
  logic [BUCKET_W:0]   upd_sum;
  logic [BUCKET_W-1:0] upd_sat, wr_bytes;
  logic [TIME_W-1:0]   wr_start;

  function automatic logic [SUM_W-1:0] sat_acc(logic [SUM_W-1:0] s, logic [BUCKET_W-1:0] b);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W+1)'(b);
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  assign start1_m  = zero1_r ? '0 : start1_r;
  assign bytes1_m  = zero1_r ? '0 : bytes1_r;
  assign next_slot = (newest_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : newest_r + SLOT_W'(1);
  assign prev_slot = (rd_addr_r == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : rd_addr_r - SLOT_W'(1);

  assign gap      = $signed(diff2_r) > $signed(NEW_BUCKET_GAP);
  assign upd_sum  = {1'b0, bytes2_r} + (BUCKET_W+1)'(bytes_r);
  assign upd_sat  = upd_sum[BUCKET_W] ? BUCKET_MAX : upd_sum[BUCKET_W-1:0];
  assign wr_addr  = gap ? next_slot : newest_r;
  assign wr_start = gap ? time_r : start2_r;
  assign wr_bytes = gap ? BUCKET_W'(bytes_r) : upd_sat;

  always_ff @(posedge clk) begin
    if (cmd.rec_we) begin
      mem_start[wr_addr] <= wr_start;
      mem_bytes[wr_addr] <= wr_bytes;
    end
    if (cmd.rd_en) begin
      start1_r <= mem_start[rd_addr_r];
      bytes1_r <= mem_bytes[rd_addr_r];
      zero1_r  <= (rd_addr_r == '0) && !v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      count_r  <= CNT_W'(1);
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.rec_we) begin
        if (wr_addr == '0) v0_r <= 1'b1;
        if (gap) begin
          newest_r <= next_slot;
          if (count_r < CNT_W'(HISTORY_DEPTH)) count_r <= count_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      time_r    <= in_time_us;
      bytes_r   <= in_write_bytes;
      rd_addr_r <= newest_r;
    end else if (cmd.rd_en) begin
      rd_addr_r <= prev_slot;
    end
    if (v1_r) begin
      diff2_r  <= {1'b0, time_r} - {1'b0, start1_m};
      start2_r <= start1_m;
      bytes2_r <= bytes1_m;
    end
    if (v2_r) begin
      in_month_r <= $signed(diff2_r) < $signed(WIN_MONTH);
      in_week_r  <= $signed(diff2_r) < $signed(WIN_WEEK);
      in_day_r   <= $signed(diff2_r) < $signed(WIN_DAY);
      bytes3_r   <= bytes2_r;
    end
    if (cmd.load) begin
      s_month_r <= '0;
      s_week_r  <= '0;
      s_day_r   <= '0;
    end else if (v3_r) begin
      if (in_month_r) s_month_r <= sat_acc(s_month_r, bytes3_r);
      if (in_week_r)  s_week_r  <= sat_acc(s_week_r, bytes3_r);
      if (in_day_r)   s_day_r   <= sat_acc(s_day_r, bytes3_r);
    end
    lim_month_r <= LIMIT_W'(daily_target) * MULT_MONTH;
    lim_week_r  <= LIMIT_W'(daily_target) * MULT_WEEK;
    lim_day_r   <= LIMIT_W'(daily_target) * MULT_DAY;
    if (cmd.cmp_en) begin
      allowed_r <= (s_month_r < SUM_W'(lim_month_r)) && (s_week_r < SUM_W'(lim_week_r))
                   && (s_day_r < SUM_W'(lim_day_r));
    end
  end

  assign sts.count     = count_r;
  assign sts.pipe_busy = v1_r | v2_r | v3_r;

  assign out_allowed   = allowed_r;
  assign out_sum_month = s_month_r;
  assign out_sum_week  = s_week_r;
  assign out_sum_day   = s_day_r;

endmodule

// ===== design/write_budget_window_limiter.sv =====
// ----------------------------------------------------------------------------
// write_budget_window_limiter
// Day-bucket ring of written bytes with 28/7/1 day window budget check.
//
//   channel  ports                                 handshake
//   input    in_func, in_time_us, in_write_bytes   start & !busy
//   result   out_allowed, out_sum_*                out_valid, one cycle
//   config   psel/penable/pwrite/paddr/pwdata      APB, pready tied high
//
// A record word steps through a read, an age and a write back to the ring memory.
// A query word walks every live bucket: the ring memory
// read port delivers one bucket per cycle into a three-stage age pipeline.
// Reset (synchronous, rst_n low) leaves one empty bucket at time 0.
// Results are strobed for a single cycle and cannot be held off.
// ----------------------------------------------------------------------------
module write_budget_window_limiter
  import wbwl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [TIME_W-1:0]   in_time_us,
  input  logic [BYTES_W-1:0]  in_write_bytes,
  output logic                out_valid,
  output logic                out_allowed,
  output logic [SUM_W-1:0]    out_sum_month,
  output logic [SUM_W-1:0]    out_sum_week,
  output logic [SUM_W-1:0]    out_sum_day,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  wbwl_cmd_t           cmd;
  wbwl_sts_t           sts;
  logic [TARGET_W-1:0] target_r;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[3] == REG_DAILY_TARGET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_we) begin
      target_r <= pwdata[TARGET_W-1:0];
    end
  end

  assign prdata = (paddr[3] == REG_DAILY_TARGET) ? DATA_W'(target_r) : '0;

  wbwl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  wbwl_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_time_us     (in_time_us),
    .in_write_bytes (in_write_bytes),
    .daily_target   (target_r),
    .out_allowed    (out_allowed),
    .out_sum_month  (out_sum_month),
    .out_sum_week   (out_sum_week),
    .out_sum_day    (out_sum_day)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.count != '0) && (sts.count <= CNT_W'(HISTORY_DEPTH)))
    else $error("bucket count out of range");

  a_drained_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !sts.pipe_busy)
    else $error("result strobed before age pipeline drained");

endmodule

// ===== tb/sv/tb_write_budget_window_limiter.sv =====
// ----------------------------------------------------------------------------
// tb_write_budget_window_limiter
// Self-checking bench for the day-bucket write budget limiter. A behavioural
// copy of the bucket ring predicts every query result. Directed words cover
// the bucket and window boundaries and the time extremes. Random phases then
// run record and query traffic under several daily targets, including a burst
// that saturates a bucket and long runs that wrap the ring.
// ----------------------------------------------------------------------------
module tb_write_budget_window_limiter;
  timeunit 1ns;
  timeprecision 1ps;
  import wbwl_pkg::*;

  localparam int TARGET_IDX = int'(REG_DAILY_TARGET);
  localparam int SPARE_IDX  = 1;

  localparam logic [63:0] HOUR_US = 64'd3600000000;
  localparam logic [63:0] DAY_US  = 64'(US_PER_DAY);

  localparam logic [TIME_W-1:0]  GAP_T     = TIME_W'(NEW_BUCKET_GAP);
  localparam logic [TIME_W-1:0]  DAY_T     = TIME_W'(WIN_DAY);
  localparam logic [TIME_W-1:0]  WEEK_T    = TIME_W'(WIN_WEEK);
  localparam logic [TIME_W-1:0]  MONTH_T   = TIME_W'(WIN_MONTH);
  localparam logic [TIME_W-1:0]  TIME_TOP  = '1;
  localparam logic [BYTES_W-1:0] BYTES_TOP = '1;

  typedef struct {
    logic             allowed;
    logic [SUM_W-1:0] month;
    logic [SUM_W-1:0] week;
    logic [SUM_W-1:0] day;
  } budget_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic                in_func        = FUNC_RECORD;
  logic [TIME_W-1:0]   in_time_us     = '0;
  logic [BYTES_W-1:0]  in_write_bytes = '0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ADDR_W-1:0]   paddr          = '0;
  logic [DATA_W-1:0]   pwdata         = '0;
  logic                busy;
  logic                out_valid;
  logic                out_allowed;
  logic [SUM_W-1:0]    out_sum_month;
  logic [SUM_W-1:0]    out_sum_week;
  logic [SUM_W-1:0]    out_sum_day;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [TIME_W-1:0]   ring_start [HISTORY_DEPTH];
  logic [BUCKET_W-1:0] ring_bytes [HISTORY_DEPTH];
  int                  newest_idx;
  int                  live_buckets;
  logic [TARGET_W-1:0] day_target;

  budget_t             budget_q [$];
  int                  mismatches = 0;
  bit                  no_gaps    = 1'b0;
  logic [TIME_W-1:0]   traffic_now;

  write_budget_window_limiter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_time_us     (in_time_us),
    .in_write_bytes (in_write_bytes),
    .out_valid      (out_valid),
    .out_allowed    (out_allowed),
    .out_sum_month  (out_sum_month),
    .out_sum_week   (out_sum_week),
    .out_sum_day    (out_sum_day),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand_bits64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] field_mask(int bits);
    return (64'd1 << bits) - 64'd1;
  endfunction

  function automatic longint bucket_age(logic [TIME_W-1:0] now, logic [TIME_W-1:0] origin);
    return longint'({2'b00, now}) - longint'({2'b00, origin});
  endfunction

  function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] ceiling);
    logic [63:0] s;
    s = a + b;
    return (s > ceiling) ? ceiling : s;
  endfunction

  function void reset_ring();
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      ring_start[i] = '0;
      ring_bytes[i] = '0;
    end
    newest_idx   = 0;
    live_buckets = 1;
    day_target   = '0;
    traffic_now  = '0;
  endfunction

  function void apply_config(int idx, logic [DATA_W-1:0] value);
    if (idx == TARGET_IDX) begin
      day_target = value[TARGET_W-1:0];
    end
  endfunction

  // Advance the bucket ring by one word; a query queues its window sums.
  function void apply_word(logic func, logic [TIME_W-1:0] now, logic [BYTES_W-1:0] bytes);
    budget_t     res;
    longint      age;
    logic [63:0] s28;
    logic [63:0] s7;
    logic [63:0] s1;
    int          idx;
    if (func == FUNC_RECORD) begin
      if (bucket_age(now, ring_start[newest_idx]) > longint'(NEW_BUCKET_GAP)) begin
        newest_idx = (newest_idx + 1) % HISTORY_DEPTH;
        ring_start[newest_idx] = now;
        ring_bytes[newest_idx] = BUCKET_W'(bytes);
        if (live_buckets < HISTORY_DEPTH) begin
          live_buckets++;
        end
      end else begin
        ring_bytes[newest_idx] = BUCKET_W'(clamp_add(64'(ring_bytes[newest_idx]), 64'(bytes),
                                                     64'(BUCKET_MAX)));
      end
    end else begin
      s28 = '0;
      s7  = '0;
      s1  = '0;
      for (int k = 0; k < live_buckets; k++) begin
        idx = (newest_idx + HISTORY_DEPTH - k) % HISTORY_DEPTH;
        age = bucket_age(now, ring_start[idx]);
        if (age < longint'(WIN_MONTH)) s28 = clamp_add(s28, 64'(ring_bytes[idx]), 64'(SUM_MAX));
        if (age < longint'(WIN_WEEK))  s7  = clamp_add(s7, 64'(ring_bytes[idx]), 64'(SUM_MAX));
        if (age < longint'(WIN_DAY))   s1  = clamp_add(s1, 64'(ring_bytes[idx]), 64'(SUM_MAX));
      end
      res.allowed = (s28 < 64'(day_target) * 64'(MULT_MONTH)) &&
                    (s7 < 64'(day_target) * 64'(MULT_WEEK)) &&
                    (s1 < 64'(day_target) * 64'(MULT_DAY));
      res.month = SUM_W'(s28);
      res.week  = SUM_W'(s7);
      res.day   = SUM_W'(s1);
      budget_q.push_back(res);
    end
  endfunction

  function automatic void flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    budget_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (budget_q.size() == 0) begin
        flag_mismatch("result with no query pending, sum_month", '0, 64'(out_sum_month));
      end else begin
        want = budget_q.pop_front();
        if (out_allowed !== want.allowed)
          flag_mismatch("allowed", 64'(want.allowed), 64'(out_allowed));
        if (out_sum_month !== want.month)
          flag_mismatch("sum_month", 64'(want.month), 64'(out_sum_month));
        if (out_sum_week !== want.week)
          flag_mismatch("sum_week", 64'(want.week), 64'(out_sum_week));
        if (out_sum_day !== want.day)
          flag_mismatch("sum_day", 64'(want.day), 64'(out_sum_day));
      end
    end
  end

  // Hold start high after acceptance; only an idle gap or a pause drops it.
  task automatic send_word(logic func, logic [TIME_W-1:0] t, logic [BYTES_W-1:0] b);
    int gap;
    if (!no_gaps && $urandom_range(0, 99) < 15) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 45) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_func        <= func;
    in_time_us     <= t;
    in_write_bytes <= b;
    do @(posedge clk); while (busy);
    apply_word(func, t, b);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (budget_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(int idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(8 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_config(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_zero_target_reset();
    send_word(FUNC_QUERY, '0, '0);
    send_word(FUNC_QUERY, TIME_TOP, BYTES_TOP);
  endtask

  task automatic test_bucket_boundaries();
    send_word(FUNC_RECORD, '0, BYTES_TOP);
    send_word(FUNC_RECORD, GAP_T, 40'd1);
    send_word(FUNC_RECORD, GAP_T + 1, 40'h5555555555);
    send_word(FUNC_RECORD, TIME_W'(5), 40'hAAAAAAAAAA);
    send_word(FUNC_QUERY, '0, '0);
  endtask

  task automatic test_window_edges();
    send_word(FUNC_QUERY, GAP_T + DAY_T, '0);
    send_word(FUNC_QUERY, GAP_T + 1 + DAY_T, '0);
    send_word(FUNC_QUERY, WEEK_T - 1, '0);
    send_word(FUNC_QUERY, WEEK_T, '0);
    send_word(FUNC_QUERY, MONTH_T - 1, '0);
    send_word(FUNC_QUERY, MONTH_T, '0);
  endtask

  task automatic test_time_extremes();
    wait_quiet();
    cfg_write(TARGET_IDX, '1);
    send_word(FUNC_QUERY, MONTH_T + 5, '0);
    send_word(FUNC_RECORD, TIME_TOP, BYTES_TOP);
    send_word(FUNC_QUERY, TIME_TOP, '0);
    send_word(FUNC_QUERY, '0, BYTES_TOP);
  endtask

  task automatic test_register_decode();
    wait_quiet();
    cfg_write(SPARE_IDX, '0);
    send_word(FUNC_QUERY, TIME_TOP, '0);
    wait_quiet();
    cfg_write(TARGET_IDX, 64'd1);
    send_word(FUNC_QUERY, TIME_TOP, '0);
  endtask

  // Mostly day-scale record traffic with queries on and around window edges.
  task automatic run_traffic(int n_items, int byte_bits, bit heavy);
    logic [TIME_W-1:0]  t;
    logic [BYTES_W-1:0] b;
    logic [TIME_W-1:0]  w;
    int                 pick;
    int                 idx;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_quiet();
      if ($urandom_range(0, 99) < (heavy ? 20 : 25)) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          idx = (newest_idx + HISTORY_DEPTH - $urandom_range(0, live_buckets - 1))
                % HISTORY_DEPTH;
          case ($urandom_range(0, 2))
            0: w = DAY_T;
            1: w = WEEK_T;
            default: w = MONTH_T;
          endcase
          t = ring_start[idx] + w - TIME_W'($urandom_range(0, 1));
        end else if (pick < 90) begin
          t = traffic_now + TIME_W'(rand_bits64() % (30 * DAY_US));
        end else if (pick < 95) begin
          t = traffic_now - TIME_W'(rand_bits64() % (3 * DAY_US));
        end else begin
          t = TIME_W'(rand_bits64());
        end
        send_word(FUNC_QUERY, t, BYTES_W'(rand_bits64()));
      end else begin
        pick = $urandom_range(0, 99);
        if (heavy) begin
          traffic_now = traffic_now + TIME_W'($urandom_range(0, 120000000));
        end else if (pick < 50) begin
          traffic_now = traffic_now + TIME_W'(rand_bits64() % (12 * HOUR_US));
        end else if (pick < 78) begin
          traffic_now = traffic_now + GAP_T + TIME_W'(rand_bits64() % (3 * DAY_US));
        end else if (pick < 82) begin
          traffic_now = ring_start[newest_idx] + GAP_T + TIME_W'($urandom_range(0, 1));
        end else if (pick < 89) begin
          traffic_now = traffic_now + TIME_W'(rand_bits64() % (40 * DAY_US));
        end else if (pick < 95) begin
          traffic_now = traffic_now - TIME_W'(rand_bits64() % (3 * DAY_US));
        end else begin
          traffic_now = TIME_W'(rand_bits64());
        end
        pick = $urandom_range(0, 99);
        if (heavy) b = BYTES_TOP - BYTES_W'($urandom_range(0, 255));
        else if (pick < 5) b = BYTES_W'(field_mask(byte_bits));
        else if (pick < 10) b = '0;
        else b = BYTES_W'(rand_bits64() & field_mask(byte_bits));
        send_word(FUNC_RECORD, traffic_now, b);
      end
    end
  endtask

  task automatic test_random_traffic();
    wait_quiet();
    cfg_write(TARGET_IDX, rand_bits64() & field_mask(20));
    run_traffic(300, 20, 1'b0);
    wait_quiet();
    cfg_write(TARGET_IDX, '1);
    run_traffic(250, 40, 1'b0);
    wait_quiet();
    cfg_write(TARGET_IDX, rand_bits64());
    run_traffic(400, 40, 1'b1);
    wait_quiet();
    cfg_write(TARGET_IDX, '0);
    run_traffic(200, 32, 1'b0);
    wait_quiet();
    cfg_write(TARGET_IDX, rand_bits64() & field_mask(34));
    no_gaps = 1'b1;
    run_traffic(300, 32, 1'b0);
    no_gaps = 1'b0;
    wait_quiet();
    cfg_write(TARGET_IDX, 64'($urandom_range(1, 1000)));
    run_traffic(250, 10, 1'b0);
  endtask

  initial begin
    reset_ring();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_target_reset();
    test_bucket_boundaries();
    test_window_edges();
    test_time_extremes();
    test_register_decode();
    test_random_traffic();
    start <= 1'b0;
    while (budget_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && budget_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
